@@ hdl/mfdl_pkg.sv @@
// Shared constants and the sequencer-to-lane control bundle for the
// modulated fractional delay line. No dependencies.
package mfdl_pkg;

  localparam int RING_DEPTH_DEFAULT  = 4096;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  localparam int RATE_BITS  = 18;
  localparam int DELAY_BITS = 24;
  localparam int FRAC_BITS  = 16;

  localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);

  // one-hot strobes from the sequencer, one per step of an item
  typedef struct packed {
    logic write;  // item accepted: store samples, form delay product
    logic addr;   // saturate delay, form tap address and fraction
    logic rd_a;   // read older tap
    logic rd_b;   // read newer tap, hold older one
    logic blend;  // multiply tap difference by fraction
  } mfdl_ctrl_t;

endpackage

@@ hdl/mfdl_lane.sv @@
// One channel of the delay line: ring memory, delay-to-samples conversion
// and linear interpolation. Depends on mfdl_pkg; driven by the top-level sequencer.
module mfdl_lane #(
  parameter int RING_DEPTH  = mfdl_pkg::RING_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = mfdl_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  mfdl_pkg::mfdl_ctrl_t                 ctrl,
  input  logic [$clog2(RING_DEPTH)-1:0]        wr_addr,
  input  logic                                 full,
  input  logic [mfdl_pkg::RATE_BITS-1:0]       rate,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [mfdl_pkg::DELAY_BITS-1:0]      delay_time,
  output logic signed [SAMPLE_BITS-1:0]        result
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int FB    = mfdl_pkg::FRAC_BITS;
  localparam int PRODW = mfdl_pkg::DELAY_BITS + mfdl_pkg::RATE_BITS;
  localparam int SHIFT = mfdl_pkg::DELAY_BITS - FB;
  localparam int D16W  = PRODW - SHIFT;
  localparam int PW    = AW + FB;
  localparam int MW    = SAMPLE_BITS + FB + 2;
  localparam logic [D16W-1:0] MAX_D16 = D16W'(RING_DEPTH - 2) << FB;
  localparam logic signed [MW-1:0] HALF = MW'(1) << (FB - 1);

  logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd;
  logic signed [SAMPLE_BITS-1:0] ha;
  logic signed [SAMPLE_BITS-1:0] hb;
  logic [PRODW-1:0]              prod;
  logic [AW-1:0]                 base;
  logic [AW-1:0]                 a_q;
  logic [AW-1:0]                 b_addr;
  logic [FB-1:0]                 f_q;
  logic signed [MW-1:0]          mul;

  logic [D16W-1:0]               d16;
  logic [PW-1:0]                 d_sat;
  logic [PW-1:0]                 pos;
  logic [AW-1:0]                 rd_addr;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [MW-1:0]          rsum;

  assign d16     = prod[PRODW-1:SHIFT];
  assign d_sat   = (d16 > MAX_D16) ? PW'(MAX_D16) : PW'(d16);
  assign pos     = {base, {FB{1'b0}}} - d_sat;
  assign b_addr  = a_q + 1'b1;
  assign rd_addr = ctrl.rd_b ? b_addr : a_q;

  // entries not yet written since reset read as zero
  assign hb   = (full || (b_addr <= base)) ? rd : '0;
  assign diff = $signed({hb[SAMPLE_BITS-1], hb}) - $signed({ha[SAMPLE_BITS-1], ha});

  // ha*(1-f) + hb*f rounded == ha + round(diff*f)
  assign rsum   = mul + HALF;
  assign result = ha + SAMPLE_BITS'(rsum >>> FB);

  // single-port ring: at most one access per cycle
  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      ring[wr_addr] <= sample;
    end else if (ctrl.rd_a || ctrl.rd_b) begin
      rd <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      prod <= delay_time * rate;
      base <= wr_addr;
    end
    if (ctrl.addr) begin
      a_q <= pos[PW-1:FB];
      f_q <= pos[FB-1:0];
    end
    if (ctrl.rd_b) begin
      ha <= (full || (a_q <= base)) ? rd : '0;
    end
    if (ctrl.blend) begin
      mul <= diff * $signed({1'b0, f_q});
    end
  end

endmodule

@@ hdl/modulated_fractional_delay_line.sv @@
// Stereo modulated fractional delay line: sequencer, write position, rate
// register and output register. Depends on mfdl_pkg and mfdl_lane.
//
// The sequencer steps each accepted item through the delay multiply, the
// tap address, two reads of the single-port ring per channel and the blend
// multiply, then loads the result into the output register once any result
// held there is taken. in_stall is high until the load, so a new item is
// accepted from the cycle after it; a finished result waits there while the
// next item is accepted. Ring entries never written since reset read as zero
// through a fill flag, so there is no clearing pass: the block is ready
// straight after reset. The user must write sample_rate through the cfg port
// only while idle; the block itself does not enforce this.
module modulated_fractional_delay_line #(
  parameter int RING_DEPTH  = mfdl_pkg::RING_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = mfdl_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       left_sample,
  input  logic signed [SAMPLE_BITS-1:0]       right_sample,
  input  logic [mfdl_pkg::DELAY_BITS-1:0]     left_delay_time,
  input  logic [mfdl_pkg::DELAY_BITS-1:0]     right_delay_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       left_delayed,
  output logic signed [SAMPLE_BITS-1:0]       right_delayed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfdl_pkg::RATE_BITS-1:0]      cfg_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR, S_RDA, S_RDB, S_BLEND, S_FIN
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   wp;
  logic                            full;
  logic [mfdl_pkg::RATE_BITS-1:0]  sample_rate;
  mfdl_pkg::mfdl_ctrl_t            ctrl;
  logic                            accept;
  logic signed [SAMPLE_BITS-1:0]   left_result;
  logic signed [SAMPLE_BITS-1:0]   right_result;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign ctrl.write = accept;
  assign ctrl.addr  = (state == S_ADDR);
  assign ctrl.rd_a  = (state == S_RDA);
  assign ctrl.rd_b  = (state == S_RDB);
  assign ctrl.blend = (state == S_BLEND);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= mfdl_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sample_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      full <= 1'b0;
    end else if (accept) begin
      wp <= wp + 1'b1;
      if (wp == LAST_POS) begin
        full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_ADDR;
          end
        end
        S_ADDR:  state <= S_RDA;
        S_RDA:   state <= S_RDB;
        S_RDB:   state <= S_BLEND;
        S_BLEND: state <= S_FIN;
        S_FIN: begin
          // hold until the previous item has been taken
          if (!out_valid || !out_stall) begin
            left_delayed  <= left_result;
            right_delayed <= right_result;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mfdl_lane #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_left (
    .clk        (clk),
    .ctrl       (ctrl),
    .wr_addr    (wp),
    .full       (full),
    .rate       (sample_rate),
    .sample     (left_sample),
    .delay_time (left_delay_time),
    .result     (left_result)
  );

  mfdl_lane #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_right (
    .clk        (clk),
    .ctrl       (ctrl),
    .wr_addr    (wp),
    .full       (full),
    .rate       (sample_rate),
    .sample     (right_sample),
    .delay_time (right_delay_time),
    .result     (right_result)
  );

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (wp == $past(wp) + 1'b1))
    else $error("write position did not advance by one on an item");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_ADDR) && in_stall)
    else $error("item accepted while another is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_valid && out_stall |=> (state == S_FIN) && out_valid)
    else $error("pending result overwritten");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("fill flag dropped without reset");

endmodule
